@@ rtl/core/sdt_pkg.sv @@
package sdt_pkg;

  localparam int SEL_W     = 11;
  localparam int SEL_IDX_W = 8;
  localparam int WORD_W    = 64;
  localparam int ADDR_W    = 32;
  localparam int ATTR_W    = 16;

  typedef logic [1:0]        action_t;
  typedef logic [1:0]        status_t;
  typedef logic [SEL_W-1:0]  sel_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ATTR_W-1:0] attr_t;

  localparam action_t ACT_WRITE = 2'd0;
  localparam action_t ACT_ALLOC = 2'd1;
  localparam action_t ACT_FREE  = 2'd2;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_RANGE = 2'd2;

  localparam addr_t LIMIT_BYTE_MAX = 32'h000F_FFFF;
  localparam attr_t ATTR_GRAN      = 16'h8000;
  localparam int    PAGE_SHIFT     = 12;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_SCAN,
    ST_RESP
  } state_t;

  // Pack base, limit and attributes into the 64-bit descriptor layout.
  function automatic word_t pack_descriptor(input addr_t base, input addr_t limit,
                                            input attr_t attr);
    addr_t lim;
    attr_t a;
    lim = limit;
    a   = attr;
    if (limit > LIMIT_BYTE_MAX) begin
      a   = a | ATTR_GRAN;
      lim = limit >> PAGE_SHIFT;
    end
    a[11:8] = a[11:8] | lim[19:16];
    return {base[31:24], a, base[23:16], base[15:0], lim[15:0]};
  endfunction

endpackage

@@ rtl/core/segment_descriptor_table.sv @@
// Flow: a request is taken in ST_IDLE. A write or free whose selector is outside the table,
// or an unused action, goes straight to ST_RESP; a write passes through ST_WRITE, a free
// through ST_FREE_RD and ST_FREE_WR, and an alloc through ST_SCAN, which reads one entry a
// cycle from entry 1 until it finds an unused entry or reaches the last one.
// Throughput: one request at a time; in_ready returns once the result is handed off.
// Reset: zero the store one entry a cycle; in_ready stays low until the pass ends.
module segment_descriptor_table #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sdt_pkg::action_t action,
  input  sdt_pkg::sel_t    selector,
  input  sdt_pkg::addr_t   seg_base,
  input  sdt_pkg::addr_t   seg_limit,
  input  sdt_pkg::attr_t   attr_word,
  output logic             out_valid,
  input  logic             out_ready,
  output sdt_pkg::status_t status,
  output sdt_pkg::sel_t    result_selector,
  output sdt_pkg::word_t   descriptor_word
);
  import sdt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] FIRST_ALLOC = IDX_W'(1);

  state_t state, state_next;

  // Latched request.
  action_t              req_action;
  logic [SEL_IDX_W-1:0] req_idx;
  addr_t                req_base;
  addr_t                req_limit;
  attr_t                req_attr;

  // Descriptor store.
  word_t            mem [TABLE_ENTRIES];
  word_t            rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  word_t            mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  // Clearing pass and alloc scan.
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] scan_addr;
  logic             issue_done;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_vld;
  logic             scan_issue;
  logic             scan_hit;
  logic             scan_last;

  // Result staging.
  status_t res_status, res_status_next;
  sel_t    res_sel, res_sel_next;
  word_t   res_word, res_word_next;
  logic    res_load;
  logic    out_load;

  logic             in_accept;
  logic             in_range;
  logic [IDX_W-1:0] req_addr;
  word_t            packed_word;

  assign in_accept   = in_valid && in_ready;
  assign in_range    = 32'(selector[SEL_W-1:3]) < TABLE_ENTRIES;
  assign req_addr    = IDX_W'(req_idx);
  assign packed_word = pack_descriptor(req_base, req_limit, req_attr);
  assign scan_hit    = rd_vld && (rdata[55:40] == '0);
  assign scan_last   = rd_vld && (rd_addr == LAST_ADDR);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_WRITE: state_next = in_range ? ST_WRITE : ST_RESP;
            ACT_ALLOC: state_next = ST_SCAN;
            ACT_FREE:  state_next = in_range ? ST_FREE_RD : ST_RESP;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_WRITE:   state_next = ST_RESP;
      ST_FREE_RD: state_next = ST_FREE_WR;
      ST_FREE_WR: state_next = ST_RESP;
      ST_SCAN: begin
        if (scan_hit || scan_last) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = req_addr;
    mem_wdata       = packed_word;
    mem_raddr       = scan_addr;
    scan_issue      = 1'b0;
    res_load        = 1'b0;
    res_status_next = STATUS_OK;
    res_sel_next    = '0;
    res_word_next   = '0;
    out_load        = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        // Preload the short answer; the longer paths overwrite it.
        res_load = in_valid;
        if ((action == ACT_WRITE || action == ACT_FREE) && !in_range) begin
          res_status_next = STATUS_RANGE;
        end
      end
      ST_WRITE: begin
        mem_we        = 1'b1;
        res_load      = 1'b1;
        res_word_next = packed_word;
      end
      ST_FREE_RD: begin
        mem_raddr = req_addr;
      end
      ST_FREE_WR: begin
        mem_we        = 1'b1;
        mem_wdata     = {rdata[63:56], 16'h0000, rdata[39:0]};
        res_load      = 1'b1;
        res_word_next = mem_wdata;
      end
      ST_SCAN: begin
        scan_issue = !issue_done;
        if (scan_hit) begin
          res_load     = 1'b1;
          res_sel_next = {8'(rd_addr), 3'b000};
        end else if (scan_last) begin
          res_load        = 1'b1;
          res_status_next = STATUS_FULL;
        end
      end
      ST_RESP: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Hold the request for the cycles it takes.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_action <= action;
      req_idx    <= selector[SEL_W-1:3];
      req_base   <= seg_base;
      req_limit  <= seg_limit;
      req_attr   <= attr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  // Advance the scan: issue one read per cycle, compare each in the cycle after its issue.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= FIRST_ALLOC;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
      rd_addr    <= '0;
    end else if (state != ST_SCAN) begin
      scan_addr  <= FIRST_ALLOC;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      rd_vld <= scan_issue;
      if (scan_issue) begin
        rd_addr    <= scan_addr;
        scan_addr  <= scan_addr + IDX_W'(1);
        issue_done <= (scan_addr == LAST_ADDR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= res_status_next;
      res_sel    <= res_sel_next;
      res_word   <= res_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status          <= res_status;
      result_selector <= res_sel;
      descriptor_word <= res_word;
    end
  end

  // An alloc never hands out entry zero.
  a_no_entry_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_hit) |-> (rd_addr != '0))
    else $error("alloc scan matched entry zero");

  // The scan only reads; the store stays untouched while it runs.
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !mem_we)
    else $error("store written during alloc scan");

  // Only writes and frees report a descriptor word.
  a_word_source: assert property (@(posedge clk) disable iff (rst)
    (res_load && res_word_next != '0) |->
      (req_action == ACT_WRITE || req_action == ACT_FREE))
    else $error("descriptor word staged for wrong action");

  // Error results carry zero fields.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |->
      (result_selector == '0 && descriptor_word == '0))
    else $error("error result with nonzero fields");

  // The clearing pass runs right after reset before any request is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("request taken before clearing pass");

endmodule
